@@ design/flm_pkg.sv @@
// Shared types, codes and helpers of the fixed-string line matcher.
`default_nettype none

package flm_pkg;

    // input item kinds (s_axis_tuser)
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    // result kinds (m_axis_tuser)
    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CASE_FOLD    = 2'd3;

    localparam int PATTERN_LEN_W     = 5;
    localparam int PATTERN_REG_BYTES = 16;
    localparam int PATTERN_IDX_W     = 4;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] NUL_BYTE     = 8'h00;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] FOLD_DELTA   = 8'd32;

    localparam int OUT_OFFSET_W = 32;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 72;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic                    result_kind;
        logic [OUT_OFFSET_W-1:0] line_start;
        logic [OUT_OFFSET_W-1:0] line_end;
        logic                    binary_file;
        logic                    any_match;
        logic                    last_of_run;
    } result_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
        logic [7:0] r;
        r = b;
        if (fold_en && b >= UPPER_A && b <= UPPER_Z)
        begin
            r = b + FOLD_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/fixed_string_line_matcher.sv @@
// Top level of the fixed-string line matcher.
//
// Input stream (s_axis): one item per file byte (tuser = 0, byte in tdata) or
// an end of file marker (tuser = 1). Output stream (m_axis): a line report
// (tuser = 0) with the start and end offsets of each line holding the pattern,
// and at end of file a summary (tuser = 1) with the binary and match flags.
// tlast is set on the last result caused by an input item.
// Configuration: cfg_write with cfg_index / cfg_data, written while idle.
// Path: an accepted item reaches the input register, is evaluated there once
// the result queue has room, and its results are written into that queue.
// Throughput: one item per cycle while the result queue has room; the window
// compare against the pattern is one parallel compare over the shifted window.
// An end of file with a pending line gives two results, drained one a cycle;
// when the receiver stalls, the four-entry result queue fills and s_axis_tready
// drops once fewer than two entries are free.
// Reset clears the configuration, all per-file state and the queue.
`default_nettype none

module fixed_string_line_matcher #(
    parameter int              PATTERN_MAX = 16,
    parameter longint unsigned PEEK_BYTES  = 65536,
    parameter int              OFFSET_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // data_byte
    input  wire logic [flm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // line_start[31:0], line_end[63:32], binary_file[64], any_match[65], zero fill
    output logic [flm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // result_kind
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_write,
    input  wire logic [flm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [flm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W = (OFFSET_BITS > 33) ? OFFSET_BITS : 33;

    // configuration
    logic [flm_pkg::CFG_DATA_W-1:0]    pattern_low_reg;
    logic [flm_pkg::CFG_DATA_W-1:0]    pattern_high_reg;
    logic [flm_pkg::PATTERN_LEN_W-1:0] pattern_length_reg;
    logic                              case_fold_reg;

    // input register
    logic                              in_valid_reg;
    logic                              in_cmd_reg;
    logic [7:0]                        in_byte_reg;

    // per-file state
    logic [7:0]                        window_reg [PATTERN_MAX];
    logic [7:0]                        window_next [PATTERN_MAX];
    logic [OFFSET_BITS-1:0]            offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]            line_start_reg, line_start_next;
    logic [LEN_W-1:0]                  fill_reg, fill_next;
    logic                              hit_reg, hit_next;
    logic                              nul_reg, nul_next;
    logic                              matched_reg, matched_next;

    logic                              fire;
    logic                              room;
    logic [1:0]                        push_valid;
    flm_pkg::result_t                  push_data [2];

    logic [7:0]                        pat_bytes [flm_pkg::PATTERN_REG_BYTES];
    logic [7:0]                        pat_aligned [PATTERN_MAX];
    logic [LEN_W-1:0]                  plen;
    logic [OFFSET_BITS-1:0]            offset_sat;
    logic                              window_eq;
    logic                              line_pending;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            pat_bytes[i]     = flm_pkg::fold_byte(pattern_low_reg[i*8 +: 8], case_fold_reg);
            pat_bytes[i + 8] = flm_pkg::fold_byte(pattern_high_reg[i*8 +: 8], case_fold_reg);
        end
    end

    // pattern laid out in window order: window entry k faces pattern byte plen-1-k
    always_comb
    begin
        int idx;
        if (int'(pattern_length_reg) > PATTERN_MAX)
        begin
            plen = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            plen = LEN_W'(pattern_length_reg);
        end
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            idx = int'(plen) - 1 - k;
            if (idx >= 0 && idx < flm_pkg::PATTERN_REG_BYTES)
            begin
                pat_aligned[k] = pat_bytes[flm_pkg::PATTERN_IDX_W'(idx)];
            end
            else
            begin
                pat_aligned[k] = '0;
            end
        end
    end

    always_comb
    begin
        window_next[0] = flm_pkg::fold_byte(in_byte_reg, case_fold_reg);
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        window_eq = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (k < int'(plen) && window_next[k] != pat_aligned[k])
            begin
                window_eq = 1'b0;
            end
        end
    end

    always_comb
    begin
        offset_sat = (offset_reg == '1) ? offset_reg : offset_reg + OFFSET_BITS'(1);
        line_pending = hit_reg || (plen == '0);

        offset_next     = offset_reg;
        line_start_next = line_start_reg;
        fill_next       = fill_reg;
        hit_next        = hit_reg;
        nul_next        = nul_reg;
        matched_next    = matched_reg;
        push_valid      = 2'b00;
        push_data[0]    = '0;
        push_data[1]    = '0;

        if (fire)
        begin
            if (in_cmd_reg == flm_pkg::CMD_EOF)
            begin
                // a last line without newline is reported only if not empty
                if (fill_reg != '0 && line_pending)
                begin
                    push_valid[0]           = 1'b1;
                    push_data[0].result_kind = flm_pkg::KIND_LINE;
                    push_data[0].line_start  = flm_pkg::OUT_OFFSET_W'(line_start_reg);
                    push_data[0].line_end    = flm_pkg::OUT_OFFSET_W'(offset_reg);
                    push_valid[1]            = 1'b1;
                    push_data[1].result_kind = flm_pkg::KIND_SUMMARY;
                    push_data[1].binary_file = nul_reg;
                    push_data[1].any_match   = !nul_reg;
                    push_data[1].last_of_run = 1'b1;
                end
                else
                begin
                    push_valid[0]            = 1'b1;
                    push_data[0].result_kind = flm_pkg::KIND_SUMMARY;
                    push_data[0].binary_file = nul_reg;
                    push_data[0].any_match   = matched_reg && !nul_reg;
                    push_data[0].last_of_run = 1'b1;
                end
                offset_next     = '0;
                line_start_next = '0;
                fill_next       = '0;
                hit_next        = 1'b0;
                nul_next        = 1'b0;
                matched_next    = 1'b0;
            end
            else
            begin
                if (in_byte_reg == flm_pkg::NUL_BYTE
                    && CMP_W'(offset_reg) < CMP_W'(PEEK_BYTES))
                begin
                    nul_next = 1'b1;
                end
                if (in_byte_reg == flm_pkg::NEWLINE_BYTE)
                begin
                    if (line_pending)
                    begin
                        push_valid[0]            = 1'b1;
                        push_data[0].result_kind = flm_pkg::KIND_LINE;
                        push_data[0].line_start  = flm_pkg::OUT_OFFSET_W'(line_start_reg);
                        push_data[0].line_end    = flm_pkg::OUT_OFFSET_W'(offset_reg);
                        push_data[0].last_of_run = 1'b1;
                        matched_next             = 1'b1;
                    end
                    fill_next       = '0;
                    hit_next        = 1'b0;
                    line_start_next = offset_sat;
                end
                else
                begin
                    if (fill_reg != LEN_W'(PATTERN_MAX))
                    begin
                        fill_next = fill_reg + LEN_W'(1);
                    end
                    if (plen != '0 && fill_next >= plen && window_eq)
                    begin
                        hit_next = 1'b1;
                    end
                end
                offset_next = offset_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            case_fold_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                flm_pkg::CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                flm_pkg::CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                flm_pkg::CFG_PATTERN_LEN:
                    pattern_length_reg <= cfg_data[flm_pkg::PATTERN_LEN_W-1:0];
                flm_pkg::CFG_CASE_FOLD:    case_fold_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                window_reg[k] <= '0;
            end
            offset_reg     <= '0;
            line_start_reg <= '0;
            fill_reg       <= '0;
            hit_reg        <= 1'b0;
            nul_reg        <= 1'b0;
            matched_reg    <= 1'b0;
        end
        else
        begin
            // the window is cleared at newline and end of file, shifted on other bytes
            if (fire)
            begin
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    if (in_cmd_reg == flm_pkg::CMD_EOF || in_byte_reg == flm_pkg::NEWLINE_BYTE)
                    begin
                        window_reg[k] <= '0;
                    end
                    else
                    begin
                        window_reg[k] <= window_next[k];
                    end
                end
            end
            offset_reg     <= offset_next;
            line_start_reg <= line_start_next;
            fill_reg       <= fill_next;
            hit_reg        <= hit_next;
            nul_reg        <= nul_next;
            matched_reg    <= matched_next;
        end
    end

    flm_out_queue u_out_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_valid    (push_valid),
        .push_data     (push_data),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ design/flm_out_queue.sv @@
// Four-entry result queue that drives the master stream side.
`default_nettype none

module flm_out_queue (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [1:0]                      push_valid,
    input  wire flm_pkg::result_t                push_data [2],
    output logic                                 room,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // line_start[31:0], line_end[63:32], binary_file[64], any_match[65], zero fill
    output logic [flm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // result_kind
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    flm_pkg::result_t                  mem_reg [flm_pkg::QUEUE_DEPTH];
    logic [flm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [flm_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [flm_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic [flm_pkg::QUEUE_CNT_W-1:0]   push_count;
    logic                              pop;
    flm_pkg::result_t                  head;

    assign head          = mem_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    // two free entries so an end of file with a pending line never overflows
    assign room = (count_reg <= flm_pkg::QUEUE_CNT_W'(flm_pkg::QUEUE_DEPTH - 2));

    assign m_axis_tdata = {
        (flm_pkg::OUT_TDATA_W - 2 * flm_pkg::OUT_OFFSET_W - 2)'(0),
        head.any_match, head.binary_file, head.line_end, head.line_start
    };
    assign m_axis_tuser = head.result_kind;
    assign m_axis_tlast = head.last_of_run;

    always_comb
    begin
        push_count  = flm_pkg::QUEUE_CNT_W'(push_valid[0]) + flm_pkg::QUEUE_CNT_W'(push_valid[1]);
        wr_ptr_next = wr_ptr_reg + flm_pkg::QUEUE_PTR_W'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + flm_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_count - flm_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid[0])
        begin
            mem_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_valid[1])
        begin
            mem_reg[wr_ptr_reg + flm_pkg::QUEUE_PTR_W'(1)] <= push_data[1];
        end
    end

endmodule

`default_nettype wire

@@ design/flm_checker.sv @@
// Port-level checks of the fixed-string line matcher, bound to the top level.
`default_nettype none

module flm_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [flm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic                               m_axis_tuser,
    input wire logic                               m_axis_tlast
);

    // a summary always closes the run of its end of file item
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == flm_pkg::KIND_SUMMARY) |-> m_axis_tlast)
        else $error("summary item without tlast");

    // line reports carry no summary flags
    a_line_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == flm_pkg::KIND_LINE)
            |-> (m_axis_tdata[65:64] == 2'b00))
        else $error("line report with summary flags set");

    // summaries carry zero offsets
    a_summary_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == flm_pkg::KIND_SUMMARY)
            |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("summary item with nonzero offsets");

    // a stalled item stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("tvalid dropped while stalled");

endmodule

bind fixed_string_line_matcher flm_checker u_flm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ sim/tb_fixed_string_line_matcher.sv @@
// Self-checking testbench for the fixed-string line matcher: directed table, then random files.
`timescale 1ns / 1ps

module tb_fixed_string_line_matcher;

    localparam int     CLK_HALF      = 5;
    localparam int     RANDOM_ITEMS  = 1500;
    localparam int     PEEK_LIMIT    = 65536;
    localparam int     WINDOW_DEPTH  = 16;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam longint LIMIT_CYCLES  = 5000000;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [flm_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = flm_pkg::CMD_DATA;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [flm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_write     = 1'b0;
    logic [flm_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [flm_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    fixed_string_line_matcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // directed rows: a register write, or an item with an optional typed-in result
    typedef struct packed {
        logic                            is_cfg;
        logic [flm_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [flm_pkg::CFG_DATA_W-1:0]  reg_value;
        logic                            command;
        logic [7:0]                      data;
        logic                            typed;
        flm_pkg::result_t                want;
    } script_row_t;

    script_row_t      script[$];
    flm_pkg::result_t expected_reports[$];
    int               mismatches  = 0;
    int               items_sent  = 0;
    int               burst_left  = 0;
    int               ready_mode  = 0;
    int               mode_left   = 0;
    int               duty_tick   = 0;
    longint           cycle_count = 0;

    // matcher model state
    logic [63:0] cfg_lo   = '0;
    logic [63:0] cfg_hi   = '0;
    logic [4:0]  cfg_len  = '0;
    logic        cfg_fold = 1'b0;
    logic [7:0]  window_q [WINDOW_DEPTH];
    logic [31:0] next_offset;
    logic [31:0] line_begin;
    int          fill_count;
    logic        hit_seen;
    logic        nul_flag;
    logic        file_hit;

    function automatic flm_pkg::result_t make_result(input logic kind, input logic [31:0] ls,
                                                     input logic [31:0] le, input logic bin,
                                                     input logic any, input logic last);
        flm_pkg::result_t r;
        r.result_kind = kind;
        r.line_start  = ls;
        r.line_end    = le;
        r.binary_file = bin;
        r.any_match   = any;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic void expect_result(input flm_pkg::result_t r);
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    function automatic int eff_len();
        return (cfg_len > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(cfg_len);
    endfunction

    function automatic logic [7:0] lowered(input logic [7:0] b);
        if (cfg_fold && b >= flm_pkg::UPPER_A && b <= flm_pkg::UPPER_Z)
        begin
            return b | 8'h20;
        end
        return b;
    endfunction

    function automatic logic [7:0] pattern_at(input int i);
        return (i < 8) ? cfg_lo[i*8 +: 8] : cfg_hi[(i-8)*8 +: 8];
    endfunction

    function automatic void clear_file_state();
        foreach (window_q[i])
        begin
            window_q[i] = '0;
        end
        next_offset = '0;
        line_begin  = '0;
        fill_count  = 0;
        hit_seen    = 1'b0;
        nul_flag    = 1'b0;
        file_hit    = 1'b0;
    endfunction

    function automatic void advance_matcher(input logic cmd, input logic [7:0] b,
                                            output flm_pkg::result_t first,
                                            output flm_pkg::result_t second,
                                            output int count);
        int               plen;
        logic [31:0]      here;
        logic [31:0]      after;
        logic             same;
        flm_pkg::result_t summary;
        plen   = eff_len();
        first  = '0;
        second = '0;
        count  = 0;
        if (cmd == flm_pkg::CMD_EOF)
        begin
            // a last line without newline is reported only if it holds bytes
            if (fill_count > 0 && (hit_seen || plen == 0))
            begin
                file_hit = 1'b1;
                first    = make_result(flm_pkg::KIND_LINE, line_begin, next_offset,
                                       1'b0, 1'b0, 1'b0);
                count    = 1;
            end
            summary = make_result(flm_pkg::KIND_SUMMARY, '0, '0, nul_flag,
                                  file_hit && !nul_flag, 1'b1);
            if (count == 0)
            begin
                first = summary;
            end
            else
            begin
                second = summary;
            end
            count++;
            clear_file_state();
            return;
        end
        here  = next_offset;
        after = (here == '1) ? here : here + 1;
        if (b == flm_pkg::NUL_BYTE && here < PEEK_LIMIT)
        begin
            nul_flag = 1'b1;
        end
        if (b == flm_pkg::NEWLINE_BYTE)
        begin
            if (hit_seen || plen == 0)
            begin
                file_hit = 1'b1;
                first    = make_result(flm_pkg::KIND_LINE, line_begin, here, 1'b0, 1'b0, 1'b1);
                count    = 1;
            end
            foreach (window_q[i])
            begin
                window_q[i] = '0;
            end
            fill_count = 0;
            hit_seen   = 1'b0;
            line_begin = after;
        end
        else
        begin
            for (int i = WINDOW_DEPTH - 1; i > 0; i--)
            begin
                window_q[i] = window_q[i-1];
            end
            window_q[0] = lowered(b);
            if (fill_count < WINDOW_DEPTH)
            begin
                fill_count++;
            end
            if (plen > 0 && fill_count >= plen)
            begin
                same = 1'b1;
                for (int i = 0; i < plen; i++)
                begin
                    if (window_q[plen-1-i] != lowered(pattern_at(i)))
                    begin
                        same = 1'b0;
                    end
                end
                if (same)
                begin
                    hit_seen = 1'b1;
                end
            end
        end
        next_offset = after;
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] b, input logic typed,
                             input flm_pkg::result_t want);
        flm_pkg::result_t r0;
        flm_pkg::result_t r1;
        int               n;
        int               gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        advance_matcher(cmd, b, r0, r1, n);
        if (typed)
        begin
            expect_result(want);
        end
        else
        begin
            if (n > 0) expect_result(r0);
            if (n > 1) expect_result(r1);
        end
        burst_left--;
        items_sent++;
    endtask

    // stop sending and let every pending result drain before touching registers
    task automatic wait_idle();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (expected_reports.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_reports.size());
            mismatches += expected_reports.size();
            expected_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [flm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [flm_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            flm_pkg::CFG_PATTERN_LOW:  cfg_lo   = val;
            flm_pkg::CFG_PATTERN_HIGH: cfg_hi   = val;
            flm_pkg::CFG_PATTERN_LEN:  cfg_len  = val[flm_pkg::PATTERN_LEN_W-1:0];
            flm_pkg::CFG_CASE_FOLD:    cfg_fold = val[0];
            default: ;
        endcase
    endtask

    // mask bits: low, high, length, fold
    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len,
                              input logic fold, input logic [3:0] mask);
        wait_idle();
        if (mask[0]) write_reg(flm_pkg::CFG_PATTERN_LOW, lo);
        if (mask[1]) write_reg(flm_pkg::CFG_PATTERN_HIGH, hi);
        if (mask[2]) write_reg(flm_pkg::CFG_PATTERN_LEN, 64'(len));
        if (mask[3]) write_reg(flm_pkg::CFG_CASE_FOLD, 64'(fold));
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] case_swap(input logic [7:0] b);
        logic letter;
        letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
        if (letter && $urandom_range(0, cfg_fold ? 1 : 7) == 0)
        begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    function automatic logic [63:0] letters();
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
        begin
            w[i*8 +: 8] = 8'h61 + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1)
            begin
                w[i*8 +: 8] = w[i*8 +: 8] ^ 8'h20;
            end
        end
        return w;
    endfunction

    // line text: mostly pattern bytes and letters, some newlines, NULs and noise
    function automatic logic [7:0] text_byte();
        int r;
        int plen;
        plen = eff_len();
        r    = $urandom_range(0, 99);
        if (r < 6) return flm_pkg::NEWLINE_BYTE;
        if (r < 8) return flm_pkg::NUL_BYTE;
        if (r < 16) return 8'($urandom_range(0, 255));
        if (r < 60 && plen > 0) return case_swap(pattern_at($urandom_range(0, plen - 1)));
        return case_swap(8'h61 + 8'($urandom_range(0, 2)));
    endfunction

    task automatic send_file();
        int         lines;
        int         len;
        int         pos;
        int         k;
        int         plen;
        logic       noise;
        logic [7:0] b;
        plen  = eff_len();
        noise = ($urandom_range(0, 7) == 0);
        lines = $urandom_range(0, 5);
        for (int ln = 0; ln < lines; ln++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
            k   = 0;
            if (plen > 0 && $urandom_range(0, 2) != 0)
            begin
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
            end
            pos = $urandom_range(0, len);
            for (int i = 0; i < len + k; i++)
            begin
                if (noise)
                    b = 8'($urandom_range(0, 255));
                else if (i >= pos && i < pos + k)
                    b = case_swap(pattern_at(i - pos));
                else
                    b = text_byte();
                send_item(flm_pkg::CMD_DATA, b, 1'b0, '0);
            end
            if (ln < lines - 1 || $urandom_range(0, 1) == 1)
            begin
                send_item(flm_pkg::CMD_DATA, flm_pkg::NEWLINE_BYTE, 1'b0, '0);
            end
        end
        send_item(flm_pkg::CMD_EOF, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic start_phase(input int phase);
        case (phase)
            0: set_config('0, '0, 5'd0, 1'b0, 4'hF);
            1: set_config(letters(), letters(), 5'd16, 1'b1, 4'hF);
            2: set_config(letters(), letters(), 5'd31, 1'b0, 4'hF);
            3: set_config('1, '1, 5'd16, 1'b1, 4'hF);
            // newline inside the pattern: never matches
            4: set_config(64'h0000_0000_0062_0A61, letters(), 5'd3, 1'b0, 4'hF);
            5: set_config(letters(), '0, 5'd1, 1'b1, 4'b0101);
            default:
                set_config(($urandom_range(0, 1) == 1) ? letters() : {$urandom, $urandom},
                           ($urandom_range(0, 1) == 1) ? letters() : {$urandom, $urandom},
                           ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(1, 5)),
                           1'($urandom_range(0, 1)), 4'($urandom_range(1, 15)));
        endcase
    endtask

    function automatic void add_item(input logic cmd, input logic [7:0] b);
        script_row_t r;
        r         = '0;
        r.command = cmd;
        r.data    = b;
        script.insert(script.size(), r);
    endfunction

    function automatic void add_typed(input logic cmd, input logic [7:0] b,
                                      input flm_pkg::result_t want);
        script_row_t r;
        r         = '0;
        r.command = cmd;
        r.data    = b;
        r.typed   = 1'b1;
        r.want    = want;
        script.insert(script.size(), r);
    endfunction

    function automatic void add_cfg(input logic [flm_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [flm_pkg::CFG_DATA_W-1:0] val);
        script_row_t r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        script.insert(script.size(), r);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        flm_pkg::result_t got;
        flm_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.result_kind = m_axis_tuser;
            got.line_start  = m_axis_tdata[31:0];
            got.line_end    = m_axis_tdata[63:32];
            got.binary_file = m_axis_tdata[64];
            got.any_match   = m_axis_tdata[65];
            got.last_of_run = m_axis_tlast;
            if (expected_reports.size() == 0)
            begin
                $error("unexpected result: kind %0d start %0h end %0h",
                       got.result_kind, got.line_start, got.line_end);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
                check_field("line_start", want.line_start, got.line_start);
                check_field("line_end", want.line_end, got.line_end);
                check_field("binary_file", 32'(want.binary_file), 32'(got.binary_file));
                check_field("any_match", 32'(want.any_match), 32'(got.any_match));
                check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            end
        end
    end

    // receiver: switches between always ready, light and heavy random stalls, duty cycle
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 400);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (duty_tick < 3);
        endcase
        duty_tick <= (duty_tick == 4) ? 0 : duty_tick + 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int   random_base;
        int   phase;
        logic writing;
        clear_file_state();
        writing = 1'b0;

        // empty pattern after reset: every line matches
        add_typed(flm_pkg::CMD_EOF, 8'hA5,
                  make_result(flm_pkg::KIND_SUMMARY, 0, 0, 1'b0, 1'b0, 1'b1));
        add_typed(flm_pkg::CMD_DATA, flm_pkg::NEWLINE_BYTE,
                  make_result(flm_pkg::KIND_LINE, 0, 0, 1'b0, 1'b0, 1'b1));
        add_item(flm_pkg::CMD_DATA, flm_pkg::NUL_BYTE);
        add_item(flm_pkg::CMD_DATA, 8'hFF);
        add_item(flm_pkg::CMD_EOF, 8'hFF);
        add_typed(flm_pkg::CMD_DATA, flm_pkg::NEWLINE_BYTE,
                  make_result(flm_pkg::KIND_LINE, 0, 0, 1'b0, 1'b0, 1'b1));
        add_typed(flm_pkg::CMD_EOF, 8'h00,
                  make_result(flm_pkg::KIND_SUMMARY, 0, 0, 1'b0, 1'b1, 1'b1));
        // "aBc" with case folding
        add_cfg(flm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0063_4261);
        add_cfg(flm_pkg::CFG_PATTERN_LEN, 64'd3);
        add_cfg(flm_pkg::CFG_CASE_FOLD, 64'd1);
        add_item(flm_pkg::CMD_DATA, 8'h78);
        add_item(flm_pkg::CMD_DATA, 8'h41);
        add_item(flm_pkg::CMD_DATA, 8'h62);
        add_item(flm_pkg::CMD_DATA, 8'h43);
        add_typed(flm_pkg::CMD_DATA, flm_pkg::NEWLINE_BYTE,
                  make_result(flm_pkg::KIND_LINE, 0, 4, 1'b0, 1'b0, 1'b1));
        add_item(flm_pkg::CMD_DATA, 8'h61);
        add_item(flm_pkg::CMD_DATA, 8'h62);
        add_item(flm_pkg::CMD_DATA, flm_pkg::NEWLINE_BYTE);
        add_item(flm_pkg::CMD_DATA, 8'h41);
        add_item(flm_pkg::CMD_DATA, 8'h42);
        add_item(flm_pkg::CMD_DATA, 8'h43);
        add_item(flm_pkg::CMD_EOF, 8'h00);
        add_cfg(flm_pkg::CFG_CASE_FOLD, 64'd0);
        add_item(flm_pkg::CMD_DATA, 8'h41);
        add_item(flm_pkg::CMD_DATA, 8'h62);
        add_item(flm_pkg::CMD_DATA, 8'h63);
        add_typed(flm_pkg::CMD_EOF, 8'h5A,
                  make_result(flm_pkg::KIND_SUMMARY, 0, 0, 1'b0, 1'b0, 1'b1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                if (!writing) wait_idle();
                write_reg(script[i].reg_index, script[i].reg_value);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                begin
                    cfg_write <= 1'b0;
                    writing = 1'b0;
                end
                send_item(script[i].command, script[i].data, script[i].typed, script[i].want);
            end
        end

        random_base = items_sent;
        phase       = 0;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            start_phase(phase);
            repeat ($urandom_range(2, 6)) send_file();
            phase++;
        end

        wait_idle();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
